### rtl/smp_pkg.sv
// shared types and constants for the servo motion profile block
// no dependencies

`timescale 1ns / 1ps

package smp_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_RUN_MODE       = 3'd0;
   localparam logic [2:0] REG_OUTPUT_ENABLE  = 3'd1;
   localparam logic [2:0] REG_TARGET_ANGLE   = 3'd2;
   localparam logic [2:0] REG_TRAVEL_RANGE   = 3'd3;
   localparam logic [2:0] REG_SLEW_SPEED     = 3'd4;
   localparam logic [2:0] REG_SWEEP_VELOCITY = 3'd5;
   localparam logic [2:0] REG_ZERO_OFFSET    = 3'd6;

   // run mode codes; the fourth code behaves as idle
   localparam logic [1:0] MODE_HOLD  = 2'd0;
   localparam logic [1:0] MODE_POS   = 2'd1;
   localparam logic [1:0] MODE_SWEEP = 2'd2;

   localparam int CSR_DATA_W = 20;
   localparam int ACCUM_W    = 9;
   localparam int STEP_W     = 20;
   localparam int ANGLE_W    = 19;
   localparam int QUEUE_DEPTH = 2;

   // reset values of the registers
   localparam logic [18:0] RANGE_RESET = 19'd180000;
   localparam logic [9:0]  SPEED_RESET = 10'd60;

   // sweep arithmetic is done in a signed word wide enough for angle +/- step
   localparam logic signed [21:0] WRAP_MDEG   = 22'sd360000;
   localparam logic signed [21:0] WRAP2_MDEG  = 22'sd720000;
   localparam logic [18:0]        WRAP_RANGE  = 19'd360000;

   typedef logic [STEP_W-1:0] step_type;

   typedef struct packed {
      logic [1:0]  run_mode;
      logic        output_enable;
      logic [19:0] target_angle;
      logic [18:0] travel_range;
      logic [9:0]  slew_speed;
      logic [10:0] sweep_velocity;
      logic [18:0] zero_offset;
   } cfg_type;

   // side effects of a register write on the motion state
   typedef struct packed {
      logic clear;
      logic set_dir;
      logic dir_up;
   } csr_evt_type;

endpackage

### rtl/servo_motion_profile_top.sv
// top level of the servo motion profile generator: register file, front end,
// step queue and back end; depends on smp_pkg, smp_front, smp_queue, smp_back

`timescale 1ns / 1ps

// Takes one elapsed-time word per clock while the step queue is not full.
// Words are summed until TICK_MS milliseconds have gathered; that word
// triggers one update whose step (speed times gathered milliseconds) is
// formed by the front end multiplier and queued. The back end applies one
// queued step per cycle to the angle state while the result register is free
// or taken, so with rsp_ready held sustained rate is one word per cycle; each
// step passes the queue, then the output register. Results are produced only
// while output_enable is set. Write the registers only when no words are in
// flight; a write restarts the millisecond count and the arrival flag, and in
// sweep mode reloads the direction from the sign of sweep_velocity.

module servo_motion_profile_top import smp_pkg::*; #(
   parameter int TICK_MS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_ms_elapsed,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [19:0]           rsp_out_angle,
   output logic [1:0]            rsp_active_mode,
   output logic                  rsp_moving_up,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   csr_evt_type csr_evt;
   logic [1:0]  new_mode;
   logic [10:0] new_vel;
   logic        q_push, q_pop, q_valid, q_full;
   step_type    q_push_step, q_step;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_RUN_MODE:       cfg_in.run_mode       = csr_wdata[1:0];
            REG_OUTPUT_ENABLE:  cfg_in.output_enable  = csr_wdata[0];
            REG_TARGET_ANGLE:   cfg_in.target_angle   = csr_wdata[19:0];
            REG_TRAVEL_RANGE:   cfg_in.travel_range   = csr_wdata[18:0];
            REG_SLEW_SPEED:     cfg_in.slew_speed     = csr_wdata[9:0];
            REG_SWEEP_VELOCITY: cfg_in.sweep_velocity = csr_wdata[10:0];
            REG_ZERO_OFFSET:    cfg_in.zero_offset    = csr_wdata[18:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // effects of a write on the motion state use the values after the write
   always_comb begin
      new_mode        = cfg_in.run_mode;
      new_vel         = cfg_in.sweep_velocity;
      csr_evt.clear   = csr_we && (csr_index <= REG_ZERO_OFFSET);
      csr_evt.set_dir = new_mode == MODE_SWEEP;
      csr_evt.dir_up  = !new_vel[10];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.run_mode       <= MODE_HOLD;
         cfg_ff.output_enable  <= 1'b0;
         cfg_ff.target_angle   <= '0;
         cfg_ff.travel_range   <= RANGE_RESET;
         cfg_ff.slew_speed     <= SPEED_RESET;
         cfg_ff.sweep_velocity <= '0;
         cfg_ff.zero_offset    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   smp_front #(
      .TICK_MS(TICK_MS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .csr_clear      (csr_evt.clear),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_ms_elapsed (req_ms_elapsed),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_push_step    (q_push_step)
   );

   smp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_step (q_push_step),
      .pop       (q_pop),
      .valid     (q_valid),
      .step      (q_step),
      .full      (q_full)
   );

   smp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .csr_evt         (csr_evt),
      .q_valid         (q_valid),
      .q_step          (q_step),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_angle   (rsp_out_angle),
      .rsp_active_mode (rsp_active_mode),
      .rsp_moving_up   (rsp_moving_up)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("step queue written while full");

   a_pop_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten before it was taken");

   a_taken_without_refill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !q_pop) |=> !rsp_valid)
      else $error("result word repeated after it was taken");

   a_push_needs_word: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (req_valid && req_ready))
      else $error("step queued without an accepted word");

endmodule

### rtl/smp_front.sv
// front end: gathers elapsed milliseconds and forms the step for each due update
// depends on smp_pkg

`timescale 1ns / 1ps

module smp_front import smp_pkg::*; #(
   parameter int TICK_MS = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 csr_clear,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_ms_elapsed,
   input  logic                 q_full,
   output logic                 q_push,
   output step_type             q_push_step
);

   logic [ACCUM_W-1:0] accum_ff;
   logic [ACCUM_W-1:0] accum_in;
   logic [ACCUM_W-1:0] sum;
   logic               accept;
   logic               due;
   logic [10:0]        speed;
   logic [10:0]        vel_mag;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign sum       = accum_ff + ACCUM_W'(req_ms_elapsed);
   assign due       = sum >= ACCUM_W'(TICK_MS);
   assign q_push    = accept && due && cfg.output_enable;

   assign vel_mag = cfg.sweep_velocity[10] ? (~cfg.sweep_velocity + 11'd1)
                                           : cfg.sweep_velocity;

   always_comb begin
      case (cfg.run_mode)
         MODE_POS:   speed = {1'b0, cfg.slew_speed};
         MODE_SWEEP: speed = vel_mag;
         default:    speed = 11'd0;
      endcase
   end

   // degrees per second times milliseconds gives millidegrees
   assign q_push_step = STEP_W'(speed) * STEP_W'(sum);

   always_comb begin
      accum_in = accum_ff;
      if (csr_clear) begin
         accum_in = '0;
      end else if (accept) begin
         accum_in = due ? '0 : sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
      end else begin
         accum_ff <= accum_in;
      end
   end

endmodule

### rtl/smp_queue.sv
// two entry queue of step words between front and back end
// depends on smp_pkg

`timescale 1ns / 1ps

module smp_queue import smp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  step_type push_step,
   input  logic     pop,
   output logic     valid,
   output step_type step,
   output logic     full
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   step_type               mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]         count_ff, count_in;

   assign valid = count_ff != '0;
   assign full  = count_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign step  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/smp_back.sv
// back end: applies each step to the angle state and holds the result word
// depends on smp_pkg

`timescale 1ns / 1ps

module smp_back import smp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  csr_evt_type csr_evt,
   input  logic        q_valid,
   input  step_type    q_step,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [19:0] rsp_out_angle,
   output logic [1:0]  rsp_active_mode,
   output logic        rsp_moving_up
);

   logic [ANGLE_W-1:0] angle_ff, angle_in;
   logic               up_ff, up_in;
   logic               reached_ff, reached_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [19:0]        out_angle_ff, out_angle_in;
   logic [1:0]         mode_ff, mode_in;
   logic               moving_up_ff;

   logic [1:0]          mode_eff;
   logic [ANGLE_W-1:0]  tgt;
   logic                tgt_above;
   logic [ANGLE_W-1:0]  mag;
   logic                arrive;
   logic signed [21:0]  cur_ext, step_ext, range_ext, v;
   logic signed [21:0]  v_wrap;
   logic [ANGLE_W-1:0]  pos_angle, sweep_angle, next_angle;
   logic                sweep_up_next;
   logic [1:0]          mode_out;

   assign q_pop = q_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      case (cfg.run_mode)
         MODE_POS:   mode_eff = reached_ff ? MODE_HOLD : MODE_POS;
         MODE_SWEEP: mode_eff = MODE_SWEEP;
         default:    mode_eff = MODE_HOLD;
      endcase
   end

   // position mode: clamp target into [0, range], then slew or arrive
   always_comb begin
      if (cfg.target_angle[19]) begin
         tgt = '0;
      end else if (cfg.target_angle[18:0] > cfg.travel_range) begin
         tgt = cfg.travel_range;
      end else begin
         tgt = cfg.target_angle[18:0];
      end
      tgt_above = tgt > angle_ff;
      mag       = tgt_above ? tgt - angle_ff : angle_ff - tgt;
      arrive    = STEP_W'(mag) <= q_step;
      if (arrive) begin
         pos_angle = tgt;
      end else if (tgt_above) begin
         pos_angle = angle_ff + ANGLE_W'(q_step);
      end else begin
         pos_angle = angle_ff - ANGLE_W'(q_step);
      end
   end

   // sweep mode: move, then wrap into one turn or bounce at the range ends
   always_comb begin
      cur_ext   = signed'({3'b000, angle_ff});
      step_ext  = signed'({2'b00, q_step});
      range_ext = signed'({3'b000, cfg.travel_range});
      v         = up_ff ? cur_ext + step_ext : cur_ext - step_ext;
      if (v < -WRAP_MDEG) begin
         v_wrap = v + WRAP2_MDEG;
      end else if (v < 22'sd0) begin
         v_wrap = v + WRAP_MDEG;
      end else if (v < WRAP_MDEG) begin
         v_wrap = v;
      end else if (v < WRAP2_MDEG) begin
         v_wrap = v - WRAP_MDEG;
      end else begin
         v_wrap = v - WRAP2_MDEG;
      end
      sweep_up_next = up_ff;
      if (cfg.travel_range >= WRAP_RANGE) begin
         sweep_angle = v_wrap[ANGLE_W-1:0];
      end else if (v > range_ext) begin
         sweep_angle   = cfg.travel_range;
         sweep_up_next = 1'b0;
      end else if (v < 22'sd0) begin
         sweep_angle   = '0;
         sweep_up_next = 1'b1;
      end else begin
         sweep_angle = v[ANGLE_W-1:0];
      end
   end

   always_comb begin
      case (mode_eff)
         MODE_POS:   next_angle = pos_angle;
         MODE_SWEEP: next_angle = sweep_angle;
         default:    next_angle = angle_ff;
      endcase
      mode_out = (mode_eff == MODE_POS && arrive) ? MODE_HOLD : mode_eff;
   end

   always_comb begin
      angle_in     = angle_ff;
      up_in        = up_ff;
      reached_in   = reached_ff;
      rsp_valid_in = rsp_valid_ff;
      out_angle_in = out_angle_ff;
      mode_in      = mode_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_evt.clear) begin
         reached_in = 1'b0;
         if (csr_evt.set_dir) begin
            up_in = csr_evt.dir_up;
         end
      end else if (q_pop) begin
         angle_in     = next_angle;
         if (mode_eff == MODE_SWEEP) begin
            up_in = sweep_up_next;
         end
         if (mode_eff == MODE_POS && arrive) begin
            reached_in = 1'b1;
         end
         rsp_valid_in = 1'b1;
         out_angle_in = 20'(next_angle) + 20'(cfg.zero_offset);
         mode_in      = mode_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff     <= '0;
         up_ff        <= 1'b1;
         reached_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         angle_ff     <= angle_in;
         up_ff        <= up_in;
         reached_ff   <= reached_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_angle_ff <= out_angle_in;
      mode_ff      <= mode_in;
      moving_up_ff <= up_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_angle   = out_angle_ff;
   assign rsp_active_mode = mode_ff;
   assign rsp_moving_up   = moving_up_ff;

endmodule
